// ===== sv/lsc_pkg.sv =====
// Package for the launch sequence controller.
// Holds payload structs, phase encoding, command/target codes and CSR map.
// No dependencies.
`default_nettype none

package lsc_pkg;

   localparam int TIMER_BITS_DEF = 32;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_BCAST_PERIOD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_RETRY    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_READY_TIMEOUT = 2'd2;

   localparam logic [15:0] BCAST_PERIOD_RST  = 16'd100;
   localparam logic [15:0] LINK_RETRY_RST    = 16'd1000;
   localparam logic [19:0] READY_TIMEOUT_RST = 20'd10000;

   localparam logic [31:0] HALF_TURN_LIMIT = 32'd30000;
   localparam logic [31:0] FULL_TURN_LIMIT = 32'd60000;

   localparam logic [2:0] CMD_ARM     = 3'd1;
   localparam logic [2:0] CMD_DISARM  = 3'd2;
   localparam logic [2:0] CMD_ABORT   = 3'd3;
   localparam logic [2:0] CMD_SPINUP  = 3'd4;
   localparam logic [2:0] CMD_RELEASE = 3'd5;

   localparam logic [1:0] MOTOR_IDLE    = 2'd0;
   localparam logic [1:0] MOTOR_RELEASE = 2'd1;
   localparam logic [1:0] MOTOR_ZERO    = 2'd2;

   localparam logic [3:0] SEQ_NOTELEM  = 4'd0;
   localparam logic [3:0] SEQ_DISARMED = 4'd1;
   localparam logic [3:0] SEQ_ARMING   = 4'd2;
   localparam logic [3:0] SEQ_ARMED    = 4'd3;
   localparam logic [3:0] SEQ_SPINUP   = 4'd4;
   localparam logic [3:0] SEQ_READY    = 4'd5;
   localparam logic [3:0] SEQ_ENGAGE   = 4'd6;
   localparam logic [3:0] SEQ_REL1     = 4'd7;
   localparam logic [3:0] SEQ_REL2     = 4'd8;
   localparam logic [3:0] SEQ_SPINDOWN = 4'd9;
   localparam logic [3:0] SEQ_ABORT    = 4'd10;

   typedef enum logic [10:0] {
      PH_NOTELEM  = 11'b000_0000_0001,
      PH_DISARMED = 11'b000_0000_0010,
      PH_ARMING   = 11'b000_0000_0100,
      PH_ARMED    = 11'b000_0000_1000,
      PH_SPINUP   = 11'b000_0001_0000,
      PH_READY    = 11'b000_0010_0000,
      PH_ENGAGE   = 11'b000_0100_0000,
      PH_REL1     = 11'b000_1000_0000,
      PH_REL2     = 11'b001_0000_0000,
      PH_SPINDOWN = 11'b010_0000_0000,
      PH_ABORT    = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [9:0]  tick_ms;
      logic [2:0]  command;
      logic        link_healthy;
      logic        trigger_is_ready;
      logic        trigger_is_engaged;
      logic        speed_reached;
      logic [15:0] measured_rpm;
   } req_type;

   typedef struct packed {
      logic [3:0] seq_state;
      logic       broadcast_now;
      logic       link_retry;
      logic       arm_request;
      logic       params_accept;
      logic       engage_request;
      logic [1:0] motor_target;
   } rsp_type;

   function automatic logic [3:0] phase_code(input phase_type ph);
      logic [3:0] code;
      case (ph)
         PH_NOTELEM:  code = SEQ_NOTELEM;
         PH_DISARMED: code = SEQ_DISARMED;
         PH_ARMING:   code = SEQ_ARMING;
         PH_ARMED:    code = SEQ_ARMED;
         PH_SPINUP:   code = SEQ_SPINUP;
         PH_READY:    code = SEQ_READY;
         PH_ENGAGE:   code = SEQ_ENGAGE;
         PH_REL1:     code = SEQ_REL1;
         PH_REL2:     code = SEQ_REL2;
         PH_SPINDOWN: code = SEQ_SPINDOWN;
         PH_ABORT:    code = SEQ_ABORT;
         default:     code = SEQ_SPINDOWN;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== sv/lsc_req_if.sv =====
// Valid/ready channel carrying one loop tick into the controller.
// Depends on lsc_pkg for the payload struct.
`default_nettype none

interface lsc_req_if import lsc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/lsc_rsp_if.sv =====
// Valid/ready channel carrying one controller result per tick.
// Depends on lsc_pkg for the payload struct.
`default_nettype none

interface lsc_rsp_if import lsc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/launch_sequence_controller.sv =====
// Launch sequence controller: one result per accepted tick.
// Depends on lsc_pkg, lsc_req_if and lsc_rsp_if.
//
// Each tick transfer on req_ch yields exactly one result transfer on rsp_ch, in order.
// A tick is captured in an input register and then decided into a result register; it
// waits there while the result register holds an untaken result, and one tick per
// clock is sustained while rsp_ch keeps up. The cycle is set by the state update path:
// a saturating timer add, a 16x16 rotation multiply and its compare. A new tick is
// taken while a finished result still waits. CSR writes are registered and are
// expected while no tick is in flight. TIMER_BITS (16..32) sets the width of the four
// saturating millisecond timers.
`default_nettype none

module launch_sequence_controller import lsc_pkg::*; #(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lsc_req_if.sink                    req_ch,
   lsc_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int TW  = TIMER_BITS;
   localparam int TW1 = TIMER_BITS + 1;
   localparam int CW  = (TIMER_BITS > 20) ? TIMER_BITS : 20;

   logic            in_valid_ff;
   req_type         in_ff;
   logic            out_valid_ff;
   rsp_type         out_ff;
   rsp_type         out_in;
   logic            advance;

   logic [15:0]     bcast_period_ff;
   logic [15:0]     link_retry_ff;
   logic [19:0]     ready_timeout_ff;

   phase_type       phase_ff, phase_in;
   logic [TW-1:0]   bcast_ff, bcast_in;
   logic [TW-1:0]   link_ff, link_in;
   logic [TW-1:0]   rdy_ff, rdy_in;
   logic [TW-1:0]   rel_ff, rel_in;

   logic [TW:0]     bcast_wide, link_wide, rdy_wide, rel_wide;
   logic [TW-1:0]   bcast_sum, link_base, link_sum, rdy_sum, rel_sum;
   logic [TW-1:0]   tick_ext;
   logic [15:0]     rel_turns;
   logic [31:0]     rel_prod;
   logic [31:0]     rel_limit;
   logic            rel_done;
   logic            bcast_hit;
   logic            is_abort;
   logic            rdy_expired;

   // handshake
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_ff <= req_ch.payload;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   // CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         bcast_period_ff  <= BCAST_PERIOD_RST;
         link_retry_ff    <= LINK_RETRY_RST;
         ready_timeout_ff <= READY_TIMEOUT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BCAST_PERIOD:  bcast_period_ff  <= csr_write_data[15:0];
            CSR_LINK_RETRY:    link_retry_ff    <= csr_write_data[15:0];
            CSR_READY_TIMEOUT: ready_timeout_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // saturating timers
   assign tick_ext   = TW'(in_ff.tick_ms);
   assign bcast_wide = {1'b0, bcast_ff} + TW1'(tick_ext);
   assign bcast_sum  = bcast_wide[TW] ? '1 : bcast_wide[TW-1:0];
   assign bcast_hit  = bcast_sum >= TW'(bcast_period_ff);

   assign link_base  = in_ff.link_healthy ? '0 : link_ff;
   assign link_wide  = {1'b0, link_base} + TW1'(tick_ext);
   assign link_sum   = link_wide[TW] ? '1 : link_wide[TW-1:0];

   assign rdy_wide    = {1'b0, rdy_ff} + TW1'(tick_ext);
   assign rdy_sum     = rdy_wide[TW] ? '1 : rdy_wide[TW-1:0];
   assign rdy_expired = CW'(rdy_sum) > CW'(ready_timeout_ff);

   // past 65534 ms any nonzero rpm clears both limits
   assign rel_wide  = {1'b0, rel_ff} + TW1'(tick_ext);
   assign rel_sum   = rel_wide[TW] ? '1 : rel_wide[TW-1:0];
   assign rel_turns = rel_sum[15:0] + 16'd1;
   assign rel_prod  = 32'(rel_turns) * 32'(in_ff.measured_rpm);
   assign rel_limit = (phase_ff == PH_REL1) ? HALF_TURN_LIMIT : FULL_TURN_LIMIT;
   assign rel_done  = (rel_sum >= TW'(17'h0FFFF)) ? (in_ff.measured_rpm != 16'd0)
                                                 : (rel_prod > rel_limit);

   assign is_abort = in_ff.command == CMD_ABORT;

   always_comb begin
      phase_in = phase_ff;
      bcast_in = bcast_hit ? '0 : bcast_sum;
      link_in  = link_ff;
      rdy_in   = rdy_ff;
      rel_in   = rel_ff;
      out_in   = '0;
      out_in.broadcast_now = bcast_hit;
      out_in.motor_target  = MOTOR_IDLE;

      case (phase_ff)
         PH_NOTELEM: begin
            if (in_ff.link_healthy) begin
               phase_in = PH_DISARMED;
            end
            link_in = link_sum;
            out_in.link_retry = link_sum >= TW'(link_retry_ff);
         end
         PH_DISARMED: begin
            if (in_ff.command == CMD_ARM) begin
               out_in.arm_request = 1'b1;
               phase_in = PH_ARMING;
            end
            out_in.params_accept = 1'b1;
         end
         PH_ARMING: begin
            if (is_abort || in_ff.command == CMD_DISARM) begin
               phase_in = PH_DISARMED;
            end else if (in_ff.trigger_is_ready) begin
               phase_in = PH_ARMED;
            end
         end
         PH_ARMED: begin
            if (is_abort || in_ff.command == CMD_DISARM) begin
               phase_in = PH_DISARMED;
            end else if (in_ff.command == CMD_SPINUP) begin
               phase_in = PH_SPINUP;
            end
         end
         PH_SPINUP: begin
            if (is_abort) begin
               phase_in = PH_ABORT;
            end else begin
               out_in.motor_target = MOTOR_RELEASE;
               if (in_ff.speed_reached) begin
                  rdy_in   = '0;
                  phase_in = PH_READY;
               end
            end
         end
         PH_READY: begin
            rdy_in = rdy_sum;
            if (is_abort || rdy_expired) begin
               phase_in = PH_ABORT;
            end else begin
               out_in.motor_target = MOTOR_RELEASE;
               if (in_ff.speed_reached && in_ff.command == CMD_RELEASE) begin
                  phase_in = PH_ENGAGE;
               end
            end
         end
         PH_ENGAGE: begin
            if (is_abort) begin
               phase_in = PH_ABORT;
            end else begin
               out_in.engage_request = 1'b1;
               if (in_ff.trigger_is_engaged) begin
                  rel_in   = '0;
                  phase_in = PH_REL1;
               end
            end
         end
         PH_REL1: begin
            rel_in = rel_sum;
            out_in.motor_target = MOTOR_RELEASE;
            if (rel_done) begin
               phase_in = PH_REL2;
            end
         end
         PH_REL2: begin
            rel_in = rel_sum;
            out_in.motor_target = MOTOR_RELEASE;
            if (rel_done) begin
               phase_in = PH_SPINDOWN;
            end
         end
         PH_SPINDOWN: begin
            out_in.motor_target = MOTOR_ZERO;
            if (in_ff.speed_reached) begin
               phase_in = PH_DISARMED;
            end
         end
         default: begin
            phase_in = PH_SPINDOWN;
         end
      endcase

      out_in.seq_state = phase_code(phase_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NOTELEM;
         bcast_ff <= '0;
         link_ff  <= '0;
         rdy_ff   <= '0;
         rel_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         bcast_ff <= bcast_in;
         link_ff  <= link_in;
         rdy_ff   <= rdy_in;
         rel_ff   <= rel_in;
      end
   end

   // checks
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_arm_goes_arming: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.payload.arm_request |->
         rsp_ch.payload.seq_state == SEQ_ARMING)
      else $error("arm strobe without move to arming");

   a_engage_state: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.payload.engage_request |->
         rsp_ch.payload.seq_state == SEQ_ENGAGE || rsp_ch.payload.seq_state == SEQ_REL1)
      else $error("engage request outside engage");

   a_accept_state: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.payload.params_accept |->
         rsp_ch.payload.seq_state == SEQ_DISARMED ||
         rsp_ch.payload.seq_state == SEQ_ARMING)
      else $error("params accept outside disarmed");

   a_zero_target: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.payload.motor_target == MOTOR_ZERO |->
         rsp_ch.payload.seq_state == SEQ_SPINDOWN ||
         rsp_ch.payload.seq_state == SEQ_DISARMED)
      else $error("spin to zero outside spindown");

endmodule

`default_nettype wire

// ===== tb/lsc_checker.sv =====
// Scoreboard for the launch sequence controller: watches both channels and the CSR port,
// predicts one result per tick transfer and compares results field by field, in order.
// Depends on lsc_pkg.
`default_nettype none

module lsc_checker import lsc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire req_type               req_payload,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire rsp_type               rsp_payload,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output int                         fail_count,
   output int                         pending
);

   logic [15:0] bcast_period;
   logic [15:0] retry_after;
   logic [19:0] ready_limit;

   logic [3:0]  seq_code;
   logic [31:0] bcast_ms;
   logic [31:0] link_down_ms;
   logic [31:0] ready_ms;
   logic [31:0] release_ms;

   rsp_type     expected_results[$];
   int          mismatches;

   function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [9:0] delta);
      logic [32:0] sum;
      sum = {1'b0, acc} + delta;
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // One loop tick of the launch sequence.
   task automatic step_sequence(input req_type t, output rsp_type r);
      logic [63:0] turn;
      r = '0;
      bcast_ms = sat_add(bcast_ms, t.tick_ms);
      if (bcast_ms >= bcast_period) begin
         r.broadcast_now = 1'b1;
         bcast_ms = '0;
      end
      case (seq_code)
         SEQ_NOTELEM: begin
            if (t.link_healthy) begin
               link_down_ms = '0;
               seq_code = SEQ_DISARMED;
            end
            link_down_ms = sat_add(link_down_ms, t.tick_ms);
            if (link_down_ms >= retry_after) r.link_retry = 1'b1;
         end
         SEQ_DISARMED: begin
            if (t.command == CMD_ARM) begin
               r.arm_request = 1'b1;
               seq_code = SEQ_ARMING;
            end
            r.params_accept = 1'b1;
         end
         SEQ_ARMING: begin
            if (t.command == CMD_ABORT || t.command == CMD_DISARM) seq_code = SEQ_DISARMED;
            else if (t.trigger_is_ready) seq_code = SEQ_ARMED;
         end
         SEQ_ARMED: begin
            if (t.command == CMD_ABORT || t.command == CMD_DISARM) seq_code = SEQ_DISARMED;
            else if (t.command == CMD_SPINUP) seq_code = SEQ_SPINUP;
         end
         SEQ_SPINUP: begin
            if (t.command == CMD_ABORT) begin
               seq_code = SEQ_ABORT;
            end else begin
               r.motor_target = MOTOR_RELEASE;
               if (t.speed_reached) begin
                  ready_ms = '0;
                  seq_code = SEQ_READY;
               end
            end
         end
         SEQ_READY: begin
            ready_ms = sat_add(ready_ms, t.tick_ms);
            if (t.command == CMD_ABORT || ready_ms > ready_limit) begin
               seq_code = SEQ_ABORT;
            end else begin
               r.motor_target = MOTOR_RELEASE;
               if (t.speed_reached && t.command == CMD_RELEASE) seq_code = SEQ_ENGAGE;
            end
         end
         SEQ_ENGAGE: begin
            if (t.command == CMD_ABORT) begin
               seq_code = SEQ_ABORT;
            end else begin
               r.engage_request = 1'b1;
               if (t.trigger_is_engaged) begin
                  release_ms = '0;
                  seq_code = SEQ_REL1;
               end
            end
         end
         SEQ_REL1: begin
            release_ms = sat_add(release_ms, t.tick_ms);
            turn = (64'(release_ms) + 64'd1) * 64'(t.measured_rpm);
            if (turn > 64'(HALF_TURN_LIMIT)) seq_code = SEQ_REL2;
            r.motor_target = MOTOR_RELEASE;
         end
         SEQ_REL2: begin
            release_ms = sat_add(release_ms, t.tick_ms);
            turn = (64'(release_ms) + 64'd1) * 64'(t.measured_rpm);
            if (turn > 64'(FULL_TURN_LIMIT)) seq_code = SEQ_SPINDOWN;
            r.motor_target = MOTOR_RELEASE;
         end
         SEQ_SPINDOWN: begin
            r.motor_target = MOTOR_ZERO;
            if (t.speed_reached) seq_code = SEQ_DISARMED;
         end
         default: begin
            seq_code = SEQ_SPINDOWN;
         end
      endcase
      r.seq_state = seq_code;
   endtask

   task automatic report(input string field, input int exp_val, input int act_val);
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, field, exp_val, act_val);
   endtask

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type e;
      if (reset) begin
         bcast_period = BCAST_PERIOD_RST;
         retry_after  = LINK_RETRY_RST;
         ready_limit  = READY_TIMEOUT_RST;
         seq_code     = SEQ_NOTELEM;
         bcast_ms     = '0;
         link_down_ms = '0;
         ready_ms     = '0;
         release_ms   = '0;
         mismatches   = 0;
         expected_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BCAST_PERIOD:  bcast_period = csr_write_data[15:0];
               CSR_LINK_RETRY:    retry_after  = csr_write_data[15:0];
               CSR_READY_TIMEOUT: ready_limit  = csr_write_data[19:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            step_sequence(req_payload, predicted);
            expected_results.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: result transfer with none expected, got %p", $time, rsp_payload);
            end else begin
               e = expected_results.pop_front();
               if (rsp_payload.seq_state !== e.seq_state)
                  report("seq_state", e.seq_state, rsp_payload.seq_state);
               if (rsp_payload.broadcast_now !== e.broadcast_now)
                  report("broadcast_now", e.broadcast_now, rsp_payload.broadcast_now);
               if (rsp_payload.link_retry !== e.link_retry)
                  report("link_retry", e.link_retry, rsp_payload.link_retry);
               if (rsp_payload.arm_request !== e.arm_request)
                  report("arm_request", e.arm_request, rsp_payload.arm_request);
               if (rsp_payload.params_accept !== e.params_accept)
                  report("params_accept", e.params_accept, rsp_payload.params_accept);
               if (rsp_payload.engage_request !== e.engage_request)
                  report("engage_request", e.engage_request, rsp_payload.engage_request);
               if (rsp_payload.motor_target !== e.motor_target)
                  report("motor_target", e.motor_target, rsp_payload.motor_target);
            end
         end
      end
      fail_count <= mismatches;
      pending    <= expected_results.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Top of the launch sequence controller testbench: clock, reset, tick stimulus, CSR phases,
// result backpressure and the verdict. Depends on lsc_pkg, lsc_req_if, lsc_rsp_if,
// launch_sequence_controller and lsc_checker.
`default_nettype none

module tb import lsc_pkg::*; ();

   localparam logic [2:0] CMD_NONE   = 3'd0;
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;
   localparam int         IDLE_LIMIT = 4000;
   localparam int         HOLD_AT    = 600;
   localparam int         HOLD_LEN   = 300;
   localparam int         PHASE_ITEMS = 235;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    fail_count;
   int                    pending;
   int                    sent = 0;
   int                    burst_left = 0;
   bit                    offering = 1'b0;
   int                    idle_cycles = 0;

   lsc_req_if req_ch ();
   lsc_rsp_if rsp_ch ();

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   launch_sequence_controller i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   lsc_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_payload      (req_ch.payload),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_payload      (rsp_ch.payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   function automatic req_type mk(input int tick, input logic [2:0] cmd, input bit healthy,
                                  input bit trig_rdy, input bit trig_eng, input bit reached,
                                  input int rpm);
      req_type t;
      t.tick_ms            = tick[9:0];
      t.command            = cmd;
      t.link_healthy       = healthy;
      t.trigger_is_ready   = trig_rdy;
      t.trigger_is_engaged = trig_eng;
      t.speed_reached      = reached;
      t.measured_rpm       = rpm[15:0];
      return t;
   endfunction

   function automatic req_type rand_tick();
      return mk($urandom_range(0, 1000), 3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom),
                1'($urandom), 1'($urandom), $urandom_range(0, 65535));
   endfunction

   // Short ticks mostly, so the ready window usually survives until release.
   function automatic req_type calm_tick();
      req_type t;
      t = rand_tick();
      t.command = CMD_NONE;
      if ($urandom_range(0, 3) != 0) t.tick_ms = 10'($urandom_range(0, 20));
      return t;
   endfunction

   task automatic send_tick(input req_type t);
      int gap;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= t;
      offering = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 15);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_step(input req_type t);
      req_type s;
      s = t;
      if ($urandom_range(0, 15) == 0) s.command = CMD_ABORT;
      send_tick(s);
   endtask

   // Arm, spin up, release, two release phases, spindown, with random filler.
   task automatic launch_run();
      req_type t;
      int      rpm;
      t = calm_tick(); t.link_healthy = 1'b1; t.command = CMD_ARM; send_step(t);
      repeat ($urandom_range(0, 2)) begin
         t = calm_tick(); t.trigger_is_ready = 1'b0; send_step(t);
      end
      t = calm_tick(); t.trigger_is_ready = 1'b1; send_step(t);
      t = calm_tick(); t.command = CMD_SPINUP; send_step(t);
      repeat ($urandom_range(0, 3)) begin
         t = calm_tick(); t.speed_reached = 1'b0; send_step(t);
      end
      t = calm_tick(); t.speed_reached = 1'b1; send_step(t);
      repeat ($urandom_range(0, 3)) begin
         t = calm_tick(); send_step(t);
      end
      t = calm_tick(); t.command = CMD_RELEASE; t.speed_reached = 1'b1; send_step(t);
      repeat ($urandom_range(0, 2)) begin
         t = calm_tick(); t.trigger_is_engaged = 1'b0; send_step(t);
      end
      t = calm_tick(); t.trigger_is_engaged = 1'b1; send_step(t);
      case ($urandom_range(0, 3))
         0:       rpm = 0;
         1:       rpm = $urandom_range(1, 100);
         default: rpm = $urandom_range(100, 65535);
      endcase
      repeat ($urandom_range(1, 8)) begin
         t = calm_tick(); t.measured_rpm = rpm[15:0]; t.command = 3'($urandom_range(0, 7));
         send_tick(t);
      end
      repeat ($urandom_range(0, 2)) begin
         t = calm_tick(); t.speed_reached = 1'b0; send_step(t);
      end
      t = calm_tick(); t.speed_reached = 1'b1; send_step(t);
   endtask

   task automatic drain();
      if (offering) begin
         req_ch.valid <= 1'b0;
         offering = 1'b0;
      end
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Receiver: changing stall patterns, plus one long hold-off while ticks keep coming.
   initial begin
      int hold_left;
      int mode;
      int mode_left;
      bit held;
      hold_left = 0;
      mode      = 0;
      mode_left = 0;
      held      = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sent >= HOLD_AT) begin
            held = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom);
               2:       rsp_ch.ready <= ($urandom_range(0, 7) != 0);
               default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_write_enable) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int target;
      req_ch.valid     <= 1'b0;
      req_ch.payload   <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass under reset settings.
      send_tick(mk(0,    CMD_NONE,    0, 0, 0, 0, 0));
      send_tick(mk(1000, CMD_NONE,    0, 0, 0, 0, 0));
      send_tick(mk(1000, CMD_SPARE7,  0, 1, 1, 1, 65535));
      send_tick(mk(1000, CMD_NONE,    1, 0, 0, 0, 0));
      send_tick(mk(5,    CMD_SPARE6,  1, 0, 0, 0, 0));
      send_tick(mk(5,    CMD_SPARE7,  1, 0, 0, 0, 0));
      send_tick(mk(5,    CMD_ARM,     1, 0, 0, 0, 0));
      send_tick(mk(5,    CMD_DISARM,  1, 1, 0, 0, 0));
      send_tick(mk(5,    CMD_ARM,     1, 0, 0, 0, 0));
      send_tick(mk(5,    CMD_NONE,    1, 1, 0, 0, 0));
      send_tick(mk(5,    CMD_ABORT,   1, 1, 0, 0, 0));
      send_tick(mk(5,    CMD_ARM,     1, 0, 0, 0, 0));
      send_tick(mk(5,    CMD_NONE,    1, 1, 0, 0, 0));
      send_tick(mk(5,    CMD_SPINUP,  1, 1, 0, 0, 0));
      send_tick(mk(5,    CMD_NONE,    1, 1, 0, 0, 0));
      send_tick(mk(5,    CMD_NONE,    1, 1, 0, 1, 0));
      send_tick(mk(5,    CMD_RELEASE, 1, 1, 0, 0, 0));
      send_tick(mk(5,    CMD_RELEASE, 1, 1, 0, 1, 0));
      send_tick(mk(5,    CMD_NONE,    1, 1, 0, 1, 0));
      send_tick(mk(5,    CMD_NONE,    1, 1, 1, 1, 0));
      send_tick(mk(1000, CMD_ABORT,   1, 1, 1, 1, 0));
      send_tick(mk(0,    CMD_NONE,    1, 1, 1, 1, 65535));
      send_tick(mk(0,    CMD_NONE,    1, 1, 1, 1, 65535));
      send_tick(mk(5,    CMD_NONE,    1, 1, 1, 0, 0));
      send_tick(mk(5,    CMD_NONE,    1, 1, 1, 1, 0));

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               write_csr(CSR_BCAST_PERIOD, 1);
               write_csr(CSR_LINK_RETRY, 1);
               write_csr(CSR_READY_TIMEOUT, 1);
            end
            1: begin
               write_csr(CSR_BCAST_PERIOD, 65535);
               write_csr(CSR_LINK_RETRY, 65535);
               write_csr(CSR_READY_TIMEOUT, 1000000);
            end
            default: begin
               write_csr(CSR_BCAST_PERIOD, $urandom_range(1, 300));
               write_csr(CSR_LINK_RETRY, $urandom_range(1, 65535));
               write_csr(CSR_READY_TIMEOUT, ($urandom_range(0, 2) == 0)
                         ? $urandom_range(1, 50) : $urandom_range(1, 5000));
            end
         endcase
         target = sent + PHASE_ITEMS;
         while (sent < target) begin
            if ($urandom_range(0, 4) != 0) begin
               launch_run();
            end else begin
               repeat ($urandom_range(1, 8)) send_tick(rand_tick());
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
